// File: rtl/stok_pkg.sv
// Shared types and constants for the script tokenizer.
// Depends on nothing; every other rtl file imports it.
`default_nettype none
package stok_pkg;

    // Byte values the scanner cares about
    localparam logic [7:0] CH_COMMENT = 8'h3B;
    localparam logic [7:0] CH_QUOTE   = 8'd34;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam int DEF_MAX_TOKEN_CHARS = 63;
    localparam int DEF_LINE_BITS       = 16;
    localparam int DEF_QUEUE_DEPTH     = 4;
    localparam int LINE_NUM_W          = 16;

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_NEWLINE,
        CLS_SEMI,
        CLS_QUOTE,
        CLS_TEXT
    } byte_class_t;

    typedef struct packed {
        logic [7:0] script_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic                  has_char;
        logic [7:0]            token_char;
        logic                  token_start;
        logic                  token_end;
        logic                  is_quoted;
        logic [LINE_NUM_W-1:0] line_number;
        logic                  crossed_newline;
        logic                  end_of_script;
    } out_item_t;

    typedef struct packed {
        byte_class_t cls;
        logic [7:0]  data;
        logic        last;
    } q_entry_t;

endpackage
`default_nettype wire

// File: rtl/stok_front.sv
// Front end: accepts script bytes and tags each with its character class.
// Depends on stok_pkg; feeds stok_queue.
`default_nettype none
module stok_front (
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire stok_pkg::in_item_t s_data,
    input  wire logic               q_full,
    output logic                    q_push,
    output stok_pkg::q_entry_t      q_wdata
);
    import stok_pkg::*;

    byte_class_t cls;

    always_comb begin
        if (s_data.script_byte == CH_NEWLINE) begin
            cls = CLS_NEWLINE;
        end else if (s_data.script_byte <= CH_SPACE) begin
            cls = CLS_SPACE;
        end else if (s_data.script_byte == CH_COMMENT) begin
            cls = CLS_SEMI;
        end else if (s_data.script_byte == CH_QUOTE) begin
            cls = CLS_QUOTE;
        end else begin
            cls = CLS_TEXT;
        end
    end

    assign s_ready      = !q_full;
    assign q_push       = s_valid && !q_full;
    assign q_wdata.cls  = cls;
    assign q_wdata.data = s_data.script_byte;
    assign q_wdata.last = s_data.last_byte;

endmodule
`default_nettype wire

// File: rtl/stok_queue.sv
// Short queue of classified bytes between front and back end.
// Depends on stok_pkg.
`default_nettype none
module stok_queue #(
    parameter int DEPTH = stok_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire stok_pkg::q_entry_t wdata,
    output logic                    full,
    input  wire logic               pop,
    output logic                    not_empty,
    output stok_pkg::q_entry_t      rdata
);
    import stok_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

// File: rtl/stok_back.sv
// Back end: scan state machine, line counter and result register.
// Depends on stok_pkg; drains stok_queue.
`default_nettype none
module stok_back #(
    parameter int MAX_TOKEN_CHARS = stok_pkg::DEF_MAX_TOKEN_CHARS,
    parameter int LINE_BITS       = stok_pkg::DEF_LINE_BITS
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_not_empty,
    input  wire stok_pkg::q_entry_t q_rdata,
    output logic                    q_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output stok_pkg::out_item_t     m_data
);
    import stok_pkg::*;

    localparam int LEN_W = $clog2(MAX_TOKEN_CHARS + 1);
    localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_TOKEN_CHARS);

    typedef enum logic [2:0] {
        M_SKIP,
        M_COMMENT,
        M_PLAIN,
        M_QUOTED,
        M_DROP,
        M_ENDED
    } mode_t;

    mode_t                mode_reg, mode_next;
    logic [LEN_W-1:0]     len_reg, len_next, len_inc;
    logic [LINE_BITS-1:0] line_reg, line_next, line_bump;
    logic                 nl_reg, nl_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_reg, out_next;

    logic                 produce, end_only, tok_end, cut;
    logic                 is_ws, is_nl, last;

    assign q_pop   = q_not_empty && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign len_inc   = len_reg + 1'b1;
    assign line_bump = (line_reg != '1) ? line_reg + 1'b1 : line_reg;
    assign is_nl     = (q_rdata.cls == CLS_NEWLINE);
    assign is_ws     = is_nl || (q_rdata.cls == CLS_SPACE);
    assign last      = q_rdata.last;

    always_comb begin
        mode_next = mode_reg;
        len_next  = len_reg;
        line_next = line_reg;
        nl_next   = nl_reg;
        produce   = 1'b0;
        end_only  = 1'b0;
        tok_end   = 1'b0;
        cut       = 1'b0;
        out_next  = '0;

        case (mode_reg)
            M_ENDED: begin
            end
            M_SKIP: begin
                if (is_ws) begin
                    if (is_nl) begin
                        line_next = line_bump;
                        nl_next   = 1'b1;
                    end
                    end_only = last;
                end else if (q_rdata.cls == CLS_SEMI) begin
                    mode_next = M_COMMENT;
                    end_only  = last;
                end else if (q_rdata.cls == CLS_QUOTE) begin
                    len_next = '0;
                    if (last) begin
                        produce               = 1'b1;
                        out_next.token_start  = 1'b1;
                        out_next.token_end    = 1'b1;
                        out_next.is_quoted    = 1'b1;
                        out_next.end_of_script = 1'b1;
                        nl_next               = 1'b0;
                        mode_next             = M_ENDED;
                    end else begin
                        mode_next = M_QUOTED;
                    end
                end else begin
                    len_next               = LEN_W'(1);
                    tok_end                = last || (LEN_W'(1) >= MAX_L);
                    produce                = 1'b1;
                    out_next.has_char      = 1'b1;
                    out_next.token_char    = q_rdata.data;
                    out_next.token_start   = 1'b1;
                    out_next.token_end     = tok_end;
                    out_next.end_of_script = last;
                    if (tok_end) begin
                        nl_next   = 1'b0;
                        mode_next = last ? M_ENDED : M_SKIP;
                    end else begin
                        mode_next = M_PLAIN;
                    end
                end
            end
            M_COMMENT: begin
                if (is_nl) begin
                    line_next = line_bump;
                    nl_next   = 1'b1;
                    mode_next = M_SKIP;
                end
                end_only = last;
            end
            M_PLAIN: begin
                if (is_ws || q_rdata.cls == CLS_SEMI) begin
                    produce                = 1'b1;
                    out_next.token_end     = 1'b1;
                    out_next.end_of_script = last;
                    nl_next                = 1'b0;
                    if (is_nl) begin
                        line_next = line_bump;
                        nl_next   = 1'b1;
                    end
                    if (last) begin
                        mode_next = M_ENDED;
                    end else if (q_rdata.cls == CLS_SEMI) begin
                        mode_next = M_COMMENT;
                    end else begin
                        mode_next = M_SKIP;
                    end
                end else begin
                    len_next               = len_inc;
                    tok_end                = last || (len_inc >= MAX_L);
                    produce                = 1'b1;
                    out_next.has_char      = 1'b1;
                    out_next.token_char    = q_rdata.data;
                    out_next.token_start   = (len_reg == '0);
                    out_next.token_end     = tok_end;
                    out_next.end_of_script = last;
                    if (tok_end) begin
                        nl_next   = 1'b0;
                        mode_next = last ? M_ENDED : M_SKIP;
                    end
                end
            end
            M_QUOTED: begin
                if (q_rdata.cls == CLS_QUOTE) begin
                    produce                = 1'b1;
                    out_next.token_start   = (len_reg == '0);
                    out_next.token_end     = 1'b1;
                    out_next.is_quoted     = 1'b1;
                    out_next.end_of_script = last;
                    nl_next                = 1'b0;
                    mode_next              = last ? M_ENDED : M_SKIP;
                end else begin
                    len_next               = len_inc;
                    cut                    = (len_inc >= MAX_L);
                    tok_end                = cut || last;
                    produce                = 1'b1;
                    out_next.has_char      = 1'b1;
                    out_next.token_char    = q_rdata.data;
                    out_next.token_start   = (len_reg == '0);
                    out_next.token_end     = tok_end;
                    out_next.is_quoted     = 1'b1;
                    out_next.end_of_script = last;
                    if (tok_end) begin
                        nl_next = 1'b0;
                    end
                    if (last) begin
                        mode_next = M_ENDED;
                    end else if (cut) begin
                        mode_next = M_DROP;
                    end
                end
            end
            M_DROP: begin
                mode_next = M_SKIP;
                end_only  = last;
            end
            default: begin
                mode_next = M_SKIP;
            end
        endcase

        // end-only result reports the line state after this byte
        if (end_only) begin
            produce                = 1'b1;
            out_next               = '0;
            out_next.end_of_script = 1'b1;
            mode_next              = M_ENDED;
        end
        out_next.line_number     = end_only ? LINE_NUM_W'(line_next) : LINE_NUM_W'(line_reg);
        out_next.crossed_newline = end_only ? nl_next : nl_reg;
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if (q_pop && produce) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= M_SKIP;
            len_reg       <= '0;
            line_reg      <= LINE_BITS'(1);
            nl_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (q_pop) begin
                mode_reg <= mode_next;
                len_reg  <= len_next;
                line_reg <= line_next;
                nl_reg   <= nl_next;
            end
            if (q_pop && produce) begin
                out_reg <= out_next;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/script_tokenizer.sv
// Script tokenizer top level: front end, byte queue and back end.
// Depends on stok_pkg, stok_front, stok_queue and stok_back.
//
// Usage
//   s_valid/s_ready/s_data carry one script byte per transaction, with
//   last_byte marking the final byte. m_valid/m_ready/m_data carry the
//   result transactions: one per token character, one per token close
//   (closing whitespace, semicolon or quote) and one for the final byte.
//   Bytes that only skip whitespace or comments give no result.
//
// Timing
//   One byte is taken per cycle sustained while m_ready stays high. The
//   front end classifies the byte and writes it into a QUEUE_DEPTH-entry
//   queue in the same cycle; the back end's scan state machine pops it
//   once the result register is empty or being taken, and loads the
//   result register. The scan state update bounds the rate.
//
// Reset and stall
//   aresetn (synchronous, active low) empties the queue, clears the result
//   register and returns the scanner to skipping whitespace on line one.
//   When m_ready is low the result is held; the back end stops popping
//   and the front end keeps accepting until the queue is full.
//   After the final byte further bytes are consumed without results.
`default_nettype none
module script_tokenizer #(
    parameter int MAX_TOKEN_CHARS = stok_pkg::DEF_MAX_TOKEN_CHARS,
    parameter int LINE_BITS       = stok_pkg::DEF_LINE_BITS,
    parameter int QUEUE_DEPTH     = stok_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire stok_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output stok_pkg::out_item_t      m_data
);
    import stok_pkg::*;

    // front end to queue
    logic     q_push;
    logic     q_full;
    q_entry_t q_wdata;

    // queue to back end
    logic     q_pop;
    logic     q_not_empty;
    q_entry_t q_rdata;

    stok_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    stok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    // scan state, line counting and the result register live here
    stok_back #(
        .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS),
        .LINE_BITS       (LINE_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_rdata     (q_rdata),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
`default_nettype wire

// File: tb/stok_token_checker.sv
`timescale 1ns / 100ps
// Token checker for the script tokenizer: watches both channels, predicts each
// result transaction from the accepted bytes and compares it field by field.
// Depends on stok_pkg for the payload types and the byte codes.
module stok_token_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  stok_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  stok_pkg::out_item_t m_data,
    output int                  mismatches,
    output int                  chars_awaited
);
    import stok_pkg::*;

    localparam int                    TOKEN_LIMIT = DEF_MAX_TOKEN_CHARS;
    localparam logic [LINE_NUM_W-1:0] LINE_CEIL   = {LINE_NUM_W{1'b1}};

    typedef enum logic [2:0] {
        SCAN_SKIP,
        SCAN_COMMENT,
        SCAN_PLAIN,
        SCAN_QUOTED,
        SCAN_DROP,
        SCAN_ENDED
    } scan_mode_e;

    scan_mode_e            mode     = SCAN_SKIP;
    int                    tok_len  = 0;
    logic [LINE_NUM_W-1:0] line_cnt = 1;
    bit                    nl_seen  = 1'b0;
    out_item_t             expected_chars[$];
    int                    bad      = 0;

    function automatic out_item_t token_result(bit has, logic [7:0] ch, bit first,
                                               bit closes, bit quoted, bit eos);
        out_item_t r;
        r.has_char        = has;
        r.token_char      = ch;
        r.token_start     = first;
        r.token_end       = closes;
        r.is_quoted       = quoted;
        r.line_number     = line_cnt;
        r.crossed_newline = nl_seen;
        r.end_of_script   = eos;
        return r;
    endfunction

    // Bare end-of-script marker; nothing is taken after it
    function automatic out_item_t script_over();
        mode = SCAN_ENDED;
        return token_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
    endfunction

    function automatic scan_mode_e after_close(bit last);
        if (last)
            return SCAN_ENDED;
        return SCAN_SKIP;
    endfunction

    function automatic void count_newline();
        if (line_cnt != LINE_CEIL)
            line_cnt++;
        nl_seen = 1'b1;
    endfunction

    task automatic scan_byte(input in_item_t item, output bit produced, output out_item_t res);
        logic [7:0] b;
        bit         last;
        bit         first;
        bit         closes;
        b        = item.script_byte;
        last     = item.last_byte;
        produced = 1'b0;
        res      = '0;
        case (mode)
            SCAN_SKIP: begin
                if (b <= CH_SPACE) begin
                    if (b == CH_NEWLINE)
                        count_newline();
                    if (last) begin
                        res      = script_over();
                        produced = 1'b1;
                    end
                end else if (b == CH_COMMENT) begin
                    mode = SCAN_COMMENT;
                    if (last) begin
                        res      = script_over();
                        produced = 1'b1;
                    end
                end else if (b == CH_QUOTE) begin
                    tok_len = 0;
                    if (last) begin
                        // opening quote as the final byte: empty quoted token
                        res      = token_result(1'b0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
                        produced = 1'b1;
                        nl_seen  = 1'b0;
                        mode     = SCAN_ENDED;
                    end else begin
                        mode = SCAN_QUOTED;
                    end
                end else begin
                    tok_len  = 1;
                    closes   = last || tok_len >= TOKEN_LIMIT;
                    res      = token_result(1'b1, b, 1'b1, closes, 1'b0, last);
                    produced = 1'b1;
                    if (closes) begin
                        nl_seen = 1'b0;
                        mode    = after_close(last);
                    end else begin
                        mode = SCAN_PLAIN;
                    end
                end
            end
            SCAN_COMMENT: begin
                if (b == CH_NEWLINE) begin
                    count_newline();
                    mode = SCAN_SKIP;
                end
                if (last) begin
                    res      = script_over();
                    produced = 1'b1;
                end
            end
            SCAN_PLAIN: begin
                if (b <= CH_SPACE || b == CH_COMMENT) begin
                    // closing byte gives a characterless end mark first
                    res      = token_result(1'b0, 8'h00, 1'b0, 1'b1, 1'b0, last);
                    produced = 1'b1;
                    nl_seen  = 1'b0;
                    if (b == CH_NEWLINE)
                        count_newline();
                    if (last)
                        mode = SCAN_ENDED;
                    else if (b == CH_COMMENT)
                        mode = SCAN_COMMENT;
                    else
                        mode = SCAN_SKIP;
                end else begin
                    first = (tok_len == 0);
                    tok_len++;
                    closes   = last || tok_len >= TOKEN_LIMIT;
                    res      = token_result(1'b1, b, first, closes, 1'b0, last);
                    produced = 1'b1;
                    if (closes) begin
                        nl_seen = 1'b0;
                        mode    = after_close(last);
                    end
                end
            end
            SCAN_QUOTED: begin
                first = (tok_len == 0);
                if (b == CH_QUOTE) begin
                    res      = token_result(1'b0, 8'h00, first, 1'b1, 1'b1, last);
                    produced = 1'b1;
                    nl_seen  = 1'b0;
                    mode     = after_close(last);
                end else begin
                    // newlines in here are characters, not line breaks
                    tok_len++;
                    closes   = last || tok_len >= TOKEN_LIMIT;
                    res      = token_result(1'b1, b, first, closes, 1'b1, last);
                    produced = 1'b1;
                    if (closes)
                        nl_seen = 1'b0;
                    if (last)
                        mode = SCAN_ENDED;
                    else if (tok_len >= TOKEN_LIMIT)
                        mode = SCAN_DROP;
                end
            end
            SCAN_DROP: begin
                // byte after a quoted cut is swallowed
                mode = SCAN_SKIP;
                if (last) begin
                    res      = script_over();
                    produced = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            bad++;
        end
    endtask

    always @(posedge aclk) begin : watch
        out_item_t want;
        out_item_t res;
        bit        produced;
        if (!aresetn) begin
            mode     = SCAN_SKIP;
            tok_len  = 0;
            line_cnt = 1;
            nl_seen  = 1'b0;
            expected_chars.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    $error("result transaction with no token result outstanding");
                    bad++;
                end else begin
                    want = expected_chars.pop_front();
                    check_field("has_char", 16'(want.has_char), 16'(m_data.has_char));
                    check_field("token_char", 16'(want.token_char), 16'(m_data.token_char));
                    check_field("token_start", 16'(want.token_start),
                                16'(m_data.token_start));
                    check_field("token_end", 16'(want.token_end), 16'(m_data.token_end));
                    check_field("is_quoted", 16'(want.is_quoted), 16'(m_data.is_quoted));
                    check_field("line_number", 16'(want.line_number),
                                16'(m_data.line_number));
                    check_field("crossed_newline", 16'(want.crossed_newline),
                                16'(m_data.crossed_newline));
                    check_field("end_of_script", 16'(want.end_of_script),
                                16'(m_data.end_of_script));
                end
            end
            if (s_valid && s_ready) begin
                scan_byte(s_data, produced, res);
                if (produced)
                    expected_chars.push_back(res);
            end
        end
        mismatches    <= bad;
        chars_awaited <= expected_chars.size();
    end

endmodule

// File: tb/script_tokenizer_test.sv
`timescale 1ns / 100ps
// Top of the script tokenizer testbench: clock, reset, byte stimulus and verdict.
// Depends on stok_pkg, script_tokenizer and stok_token_checker.
module script_tokenizer_test;
    import stok_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_BYTES = 800;
    // result trails its byte through the queue and the result register; be generous
    localparam int TAIL_CYCLES = 16;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int        mismatches;
    int        chars_awaited;

    // calm = a stretch in which neither side starts a new idle gap
    bit          calm       = 1'b0;
    int unsigned bytes_sent = 0;
    int unsigned cycles     = 0;
    int unsigned sink_hold  = 0;

    always #(HALF_PERIOD) aclk = ~aclk;

    script_tokenizer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    stok_token_checker token_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .mismatches    (mismatches),
        .chars_awaited (chars_awaited)
    );

    // Watchdog: a hung handshake must not keep the run alive
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one, none in a calm stretch
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side back-pressure; m_ready is written exactly once per edge
    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            m_ready   <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            sink_hold <= pick_gap();
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // One input transaction. Within this task valid is only dropped when a gap
    // precedes the byte, so it never falls and rises within one edge.
    task automatic send_byte(input logic [7:0] value, input bit last);
        int unsigned gap;
        in_item_t    item;
        gap              = pick_gap();
        item.script_byte = value;
        item.last_byte   = last;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    // Hold the input side off until every predicted result has been taken.
    // The checker's count is registered, hence the first wait.
    task automatic wait_for_tokens();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (chars_awaited != 0)
            @(posedge aclk);
    endtask

    task automatic send_blank();
        logic [7:0] c;
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 3) == 0)
                c = CH_NEWLINE;
            else
                c = 8'($urandom_range(0, 32));
            send_byte(c, 1'b0);
        end
    endtask

    task automatic send_comment();
        logic [7:0] c;
        send_byte(CH_COMMENT, 1'b0);
        repeat ($urandom_range(0, 10)) begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_NEWLINE);
            send_byte(c, 1'b0);
        end
        send_byte(CH_NEWLINE, 1'b0);
    endtask

    // Unquoted word; quotes may appear after the first character. Some run
    // past the length cut so the tail starts a fresh token.
    task automatic send_plain();
        int         len;
        logic [7:0] c;
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(55, 75);
        do c = 8'($urandom_range(33, 255)); while (c == CH_QUOTE || c == CH_COMMENT);
        send_byte(c, 1'b0);
        repeat (len - 1) begin
            do c = 8'($urandom_range(33, 255)); while (c == CH_COMMENT);
            send_byte(c, 1'b0);
        end
        if ($urandom_range(0, 4) == 0)
            send_comment();
        else
            send_blank();
    endtask

    // Quoted string of any bytes bar the quote; long ones get cut and the
    // following byte is swallowed, leaving the rest to be scanned as script.
    task automatic send_quoted();
        int         len;
        logic [7:0] c;
        len = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 8) : $urandom_range(55, 75);
        send_byte(CH_QUOTE, 1'b0);
        repeat (len) begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
            send_byte(c, 1'b0);
        end
        send_byte(CH_QUOTE, 1'b0);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    initial begin : stimulus
        int unsigned random_end;
        int unsigned halfway;
        bit          paused;
        int unsigned r;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening: whitespace extremes, a word closed by a comment,
        // an empty string, a string full of awkward bytes, a quote inside a
        // word and a word closed by a newline.
        send_byte(CH_SPACE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h09, 1'b0);
        send_byte(8'h21, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_COMMENT, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(CH_COMMENT, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(CH_SPACE, 1'b0);
        wait_for_tokens();

        // Random script: mostly well-formed words, strings, blanks and
        // comments, with some raw noise. Pauses once midway until drained.
        random_end = bytes_sent + RANDOM_BYTES;
        halfway    = bytes_sent + RANDOM_BYTES / 2;
        paused     = 1'b0;
        while (bytes_sent < random_end) begin
            if ($urandom_range(0, 24) == 0)
                calm <= !calm;
            if (!paused && bytes_sent >= halfway) begin
                wait_for_tokens();
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 40)
                send_plain();
            else if (r < 65)
                send_quoted();
            else if (r < 82)
                send_blank();
            else if (r < 92)
                send_comment();
            else
                send_noise();
        end

        // A last string and word before the end of the script
        calm <= 1'b0;
        send_quoted();
        send_plain();

        // Script ends on an opening quote: must close as an empty token
        send_byte(CH_SPACE, 1'b0);
        send_byte(CH_QUOTE, 1'b1);

        // Anything after the end is swallowed without a result
        repeat (4)
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        wait_for_tokens();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && chars_awaited == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
